@@ hw/rtl/tlhc_pkg.sv @@
// ----------------------------------------------------------------------------
// tlhc_pkg
// Shared types and constants for the tank level hysteresis controller.
// ----------------------------------------------------------------------------
package tlhc_pkg;

    localparam int SAMPLES_DEFAULT = 10;

    localparam int DIST_W  = 16;
    localparam int FILL_W  = 14;
    localparam int TEMP_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_AW  = 3;

    // fill divider: 16b x 14b product over a 16b divisor
    localparam int DIV_W   = 30;
    localparam int DVSR_W  = 16;

    localparam logic [BYTE_W-1:0] FRAME_HEADER = 8'hFF;
    localparam logic [FILL_W-1:0] FILL_SCALE   = 14'd10000;

    localparam logic [DIST_W-1:0]        FULL_RESET     = 16'd300;
    localparam logic [DIST_W-1:0]        OFFSET_RESET   = 16'd250;
    localparam logic [FILL_W-1:0]        LOW_RESET      = 14'd1000;
    localparam logic [FILL_W-1:0]        HIGH_RESET     = 14'd9000;
    localparam logic signed [TEMP_W-1:0] SETPOINT_RESET = 12'sd416;

    typedef enum logic [CFG_AW-1:0] {
        REG_FULL_HEIGHT = 3'd0,
        REG_OFFSET      = 3'd1,
        REG_LOW_FILL    = 3'd2,
        REG_HIGH_FILL   = 3'd3,
        REG_SETPOINT    = 3'd4
    } tlhc_reg_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_HIGH   = 2'd1,
        PH_LOW    = 2'd2
    } tlhc_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_START,
        ST_OFFSET,
        ST_LEVEL,
        ST_DIFF,
        ST_MUL,
        ST_FILL_START,
        ST_FILL_WAIT,
        ST_DECIDE,
        ST_EMIT
    } tlhc_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ hw/rtl/tank_level_hysteresis_controller.sv @@
// ----------------------------------------------------------------------------
// tank_level_hysteresis_controller
// Sensor framing, averaging, level/fill calculation and relay control.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: tuser = 0 carries a distance-sensor byte in tdata[7:0];
//   tuser = 1 carries a signed temperature sample in tdata[19:8]. Frames are
//   0xFF, high byte, low byte; nonzero distances are averaged in groups of
//   SAMPLES_PER_AVERAGE.
//   m_ channel: one transaction per completed average and per temperature
//   sample, with level, fill, both active-low relays and level_valid in tuser.
//   cfg_we/cfg_index/cfg_data write the five settings; they take effect from
//   the next result computed.
//   Flow control: a byte that does not finish an average leaves s_tready high. A
//   temperature sample passes the emit state to the output register; s_tready
//   is back when the sequencer returns to idle. A byte that finishes an average
//   passes nine sequencer steps, one of them the 30-step pass of the bit-serial
//   fill divider (that step is skipped for a zero tank height), with s_tready
//   low meanwhile. If the receiver stalls, the result is held; bytes that give
//   no result are still taken, and the next result waits in the sequencer with
//   s_tready low. Reset (synchronous, aresetn low) restores the default settings
//   and clears framing, the running sum and control state.
// ----------------------------------------------------------------------------
module tank_level_hysteresis_controller #(
    parameter int SAMPLES_PER_AVERAGE = tlhc_pkg::SAMPLES_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // sensor_byte[7:0], temperature_sample[19:8]
    input  logic                        s_tuser,   // mode

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // level_mm[15:0], fill_hundredths[29:16],
                                                   // pump_relay[30], heater_relay[31]
    output logic                        m_tuser,   // level_valid

    input  logic                        cfg_we,
    input  logic [tlhc_pkg::CFG_AW-1:0] cfg_index,
    input  logic [tlhc_pkg::CFG_W-1:0]  cfg_data
);

    localparam int CNT_W     = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int SUM_W     = tlhc_pkg::DIST_W + CNT_W;
    // sum / N taken as sum * ceil(2^AVG_SHIFT / N) >> AVG_SHIFT, exact below 2^SUM_W
    localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((longint'(1) << AVG_SHIFT) + longint'(SAMPLES_PER_AVERAGE) - 1)
                 / longint'(SAMPLES_PER_AVERAGE));

    // settings
    logic [tlhc_pkg::DIST_W-1:0]        full_reg;
    logic [tlhc_pkg::DIST_W-1:0]        offset_reg;
    logic [tlhc_pkg::FILL_W-1:0]        low_reg;
    logic [tlhc_pkg::FILL_W-1:0]        high_reg;
    logic signed [tlhc_pkg::TEMP_W-1:0] setpoint_reg;

    // working state
    tlhc_pkg::tlhc_state_t              state_reg;
    tlhc_pkg::tlhc_state_t              state_next;
    tlhc_pkg::tlhc_phase_t              phase_reg;
    logic [tlhc_pkg::BYTE_W-1:0]        high_byte_reg;
    logic [SUM_W-1:0]                   sum_reg;
    logic [CNT_W-1:0]                   count_reg;
    logic [tlhc_pkg::DIST_W-1:0]        avg_reg;
    logic [tlhc_pkg::DIST_W-1:0]        level_reg;
    logic [tlhc_pkg::DIST_W-1:0]        diff_reg;
    logic [tlhc_pkg::DIV_W-1:0]         prod_reg;
    logic [tlhc_pkg::FILL_W-1:0]        fill_reg;
    logic                               have_level_reg;
    logic                               pump_on_reg;
    logic signed [tlhc_pkg::TEMP_W-1:0] temp_reg;

    logic                               m_tvalid_reg;
    logic [31:0]                        m_tdata_reg;
    logic                               m_tuser_reg;

    logic                               s_accept;
    logic                               out_free;
    logic [tlhc_pkg::BYTE_W-1:0]        in_byte;
    logic [tlhc_pkg::DIST_W-1:0]        distance;
    logic [CNT_W-1:0]                   count_inc;
    logic                               avg_complete;
    logic [PROD_W-1:0]                  avg_prod;

    tlhc_pkg::div_req_t                 div_req;
    tlhc_pkg::div_rsp_t                 div_rsp;

    tlhc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == tlhc_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign in_byte      = s_tdata[7:0];
    assign distance     = {high_byte_reg, in_byte};
    assign count_inc    = count_reg + 1'b1;
    assign avg_complete = (count_inc == CNT_W'(SAMPLES_PER_AVERAGE));
    assign avg_prod     = PROD_W'(sum_reg) * PROD_W'(AVG_RECIP);

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg     <= tlhc_pkg::FULL_RESET;
            offset_reg   <= tlhc_pkg::OFFSET_RESET;
            low_reg      <= tlhc_pkg::LOW_RESET;
            high_reg     <= tlhc_pkg::HIGH_RESET;
            setpoint_reg <= tlhc_pkg::SETPOINT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tlhc_pkg::REG_FULL_HEIGHT: full_reg   <= cfg_data;
                tlhc_pkg::REG_OFFSET:      offset_reg <= cfg_data;
                tlhc_pkg::REG_LOW_FILL:    low_reg    <= cfg_data[tlhc_pkg::FILL_W-1:0];
                tlhc_pkg::REG_HIGH_FILL:   high_reg   <= cfg_data[tlhc_pkg::FILL_W-1:0];
                tlhc_pkg::REG_SETPOINT:
                    setpoint_reg <= $signed(cfg_data[tlhc_pkg::TEMP_W-1:0]);
                default: ;
            endcase
        end
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tlhc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser) begin
                        state_next = tlhc_pkg::ST_EMIT;
                    end else if (phase_reg == tlhc_pkg::PH_LOW && distance != '0
                                 && avg_complete) begin
                        state_next = tlhc_pkg::ST_AVG_START;
                    end
                end
            end
            tlhc_pkg::ST_AVG_START:  state_next = tlhc_pkg::ST_OFFSET;
            tlhc_pkg::ST_OFFSET:     state_next = tlhc_pkg::ST_LEVEL;
            tlhc_pkg::ST_LEVEL:      state_next = tlhc_pkg::ST_DIFF;
            tlhc_pkg::ST_DIFF:       state_next = tlhc_pkg::ST_MUL;
            tlhc_pkg::ST_MUL:        state_next = tlhc_pkg::ST_FILL_START;
            tlhc_pkg::ST_FILL_START: begin
                state_next = (full_reg == '0) ? tlhc_pkg::ST_DECIDE : tlhc_pkg::ST_FILL_WAIT;
            end
            tlhc_pkg::ST_FILL_WAIT: begin
                if (div_rsp.done) begin
                    state_next = tlhc_pkg::ST_DECIDE;
                end
            end
            tlhc_pkg::ST_DECIDE:     state_next = tlhc_pkg::ST_EMIT;
            tlhc_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = tlhc_pkg::ST_IDLE;
                end
            end
            default:                 state_next = tlhc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer: divider requests ----------------
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = full_reg;
        unique case (state_reg)
            tlhc_pkg::ST_FILL_START: begin
                div_req.start = (full_reg != '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlhc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- framing, accumulation, datapath ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= tlhc_pkg::PH_HEADER;
            high_byte_reg  <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            level_reg      <= '0;
            fill_reg       <= '0;
            have_level_reg <= 1'b0;
            pump_on_reg    <= 1'b0;
            temp_reg       <= '0;
        end else begin
            case (state_reg)
                tlhc_pkg::ST_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser) begin
                            temp_reg <= $signed(s_tdata[19:8]);
                        end else begin
                            case (phase_reg)
                                tlhc_pkg::PH_HIGH: begin
                                    high_byte_reg <= in_byte;
                                    phase_reg     <= tlhc_pkg::PH_LOW;
                                end
                                tlhc_pkg::PH_LOW: begin
                                    phase_reg <= tlhc_pkg::PH_HEADER;
                                    if (distance != '0) begin
                                        sum_reg   <= sum_reg + SUM_W'(distance);
                                        count_reg <= count_inc;
                                    end
                                end
                                default: begin
                                    phase_reg <= (in_byte == tlhc_pkg::FRAME_HEADER)
                                                 ? tlhc_pkg::PH_HIGH : tlhc_pkg::PH_HEADER;
                                end
                            endcase
                        end
                    end
                end
                tlhc_pkg::ST_AVG_START: begin
                    // average is registered this cycle
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                tlhc_pkg::ST_OFFSET: begin
                    level_reg <= (avg_reg >= offset_reg) ? avg_reg - offset_reg : '0;
                end
                tlhc_pkg::ST_LEVEL: begin
                    if (level_reg > full_reg) begin
                        level_reg <= full_reg;
                    end
                end
                tlhc_pkg::ST_FILL_START: begin
                    if (full_reg == '0) begin
                        fill_reg <= '0;
                    end
                end
                tlhc_pkg::ST_FILL_WAIT: begin
                    if (div_rsp.done) begin
                        fill_reg <= div_rsp.quotient[tlhc_pkg::FILL_W-1:0];
                    end
                end
                tlhc_pkg::ST_DECIDE: begin
                    have_level_reg <= 1'b1;
                    // off wins when the thresholds cross
                    if (fill_reg >= high_reg) begin
                        pump_on_reg <= 1'b0;
                    end else if (fill_reg < low_reg) begin
                        pump_on_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == tlhc_pkg::ST_AVG_START) begin
            avg_reg <= avg_prod[AVG_SHIFT +: tlhc_pkg::DIST_W];
        end
        if (state_reg == tlhc_pkg::ST_DIFF) begin
            diff_reg <= full_reg - level_reg;
        end
        if (state_reg == tlhc_pkg::ST_MUL) begin
            prod_reg <= tlhc_pkg::DIV_W'(diff_reg) * tlhc_pkg::DIV_W'(tlhc_pkg::FILL_SCALE);
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == tlhc_pkg::ST_EMIT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == tlhc_pkg::ST_EMIT && out_free) begin
            m_tdata_reg <= {!(temp_reg < setpoint_reg), !pump_on_reg, fill_reg, level_reg};
            m_tuser_reg <= have_level_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == tlhc_pkg::ST_FILL_WAIT))
        else $error("divider finished outside the fill wait state");

    a_level_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlhc_pkg::ST_DIFF) |-> (level_reg <= full_reg))
        else $error("level above tank height after clamp");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlhc_pkg::ST_DECIDE) |-> (fill_reg <= tlhc_pkg::FILL_SCALE))
        else $error("fill above full scale");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlhc_pkg::ST_IDLE) |-> (count_reg < CNT_W'(SAMPLES_PER_AVERAGE)))
        else $error("sample count reached the average size while idle");

endmodule

@@ hw/rtl/tlhc_div.sv @@
// ----------------------------------------------------------------------------
// tlhc_div
// Restoring divider, one quotient bit per cycle, used for the fill
// calculation.
// ----------------------------------------------------------------------------
module tlhc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  tlhc_pkg::div_req_t req,
    output tlhc_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(tlhc_pkg::DIV_W);

    logic [tlhc_pkg::DVSR_W-1:0] rem_reg;
    logic [tlhc_pkg::DVSR_W-1:0] rem_next;
    logic [tlhc_pkg::DIV_W-1:0]  quo_reg;
    logic [tlhc_pkg::DIV_W-1:0]  quo_next;
    logic [tlhc_pkg::DVSR_W-1:0] dvsr_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [tlhc_pkg::DVSR_W:0]   shifted;
    logic [tlhc_pkg::DVSR_W:0]   trial;
    logic                        fits;

    always_comb begin
        shifted  = {rem_reg, quo_reg[tlhc_pkg::DIV_W-1]};
        fits     = (shifted >= {1'b0, dvsr_reg});
        trial    = shifted - {1'b0, dvsr_reg};
        rem_next = fits ? trial[tlhc_pkg::DVSR_W-1:0] : shifted[tlhc_pkg::DVSR_W-1:0];
        quo_next = {quo_reg[tlhc_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(tlhc_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvsr_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
